// File: hw/rtl/script_token_scanner_assert.svh
// Assertion macros for the script token scanner.
`ifndef SCRIPT_TOKEN_SCANNER_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while in reset
`define STT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");
// next-cycle implication
`define STT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");
`else
`define STT_ASSERT_IMPL(label, ante, cons)
`define STT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/stt_pkg.sv
// Types and constants shared by the script token scanner modules.
package stt_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [3:0] {
        PH_START,
        PH_SKIP,
        PH_SLASH,
        PH_LINE,
        PH_BLOCK,
        PH_BLOCK_STAR,
        PH_STRING,
        PH_EOL,
        PH_EOL_SLASH,
        PH_WORD
    } phase_t;

    typedef enum logic [2:0] {
        CS_WAIT,
        CS_EVAL,
        CS_EMPTY,
        CS_MARK,
        CS_RD,
        CS_WR,
        CS_DONE
    } ctl_state_t;

    typedef struct packed {
        logic take;       // latch the input transfer
        logic clear;      // restart the token
        logic append;     // store a byte in the token
        logic app_slash;  // stored byte is '/' instead of the held byte
        logic finish;     // close the token and arm the replay
        logic trim;       // drop trailing control bytes on finish
        logic rd;         // read the token store at the replay index
        logic load_tok;   // load a token byte into the output register
        logic load_empty; // load an empty-token result
        logic load_mark;  // load the end-of-text marker
    } stt_cmd_t;

    typedef struct packed {
        logic eot;
        logic allow;
        logic eol;
        logic is_ws;
        logic is_nl;
        logic is_cr;
        logic is_slash;
        logic is_star;
        logic is_quote;
        logic raw_ok;     // untrimmed length is emittable
        logic trim_ok;    // trimmed length is emittable
        logic rep_last;   // replay index is at the last byte
        logic out_free;   // output register can take a result
    } stt_stat_t;

endpackage

// File: hw/rtl/stt_ctrl.sv
// Scanner controller: scan phase machine and result sequencing.
module stt_ctrl import stt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  stt_stat_t stat,
    output stt_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       saw_nl_reg, saw_nl_next;
    logic       allow_reg, allow_next;
    logic       eol_mode_reg, eol_mode_next;
    logic       resume_reg, resume_next;   // 1: reprocess held byte after emission

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CS_WAIT;
            phase_reg    <= PH_START;
            saw_nl_reg   <= 1'b0;
            allow_reg    <= 1'b0;
            eol_mode_reg <= 1'b0;
            resume_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            saw_nl_reg   <= saw_nl_next;
            allow_reg    <= allow_next;
            eol_mode_reg <= eol_mode_next;
            resume_reg   <= resume_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        saw_nl_next   = saw_nl_reg;
        allow_next    = allow_reg;
        eol_mode_next = eol_mode_reg;
        resume_next   = resume_reg;
        cmd           = '0;
        s_tready      = 1'b0;

        unique case (state_reg)
            CS_WAIT:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = CS_EVAL;
                end
            end
            CS_EVAL:
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        allow_next    = stat.allow;
                        eol_mode_next = stat.eol;
                        saw_nl_next   = 1'b0;
                        phase_next    = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        if (stat.eot)
                            state_next = CS_MARK;
                        else if (stat.is_ws)
                        begin
                            if (stat.is_nl)
                                saw_nl_next = 1'b1;
                            state_next = CS_WAIT;
                        end
                        else if (saw_nl_reg && !allow_reg)
                        begin
                            phase_next  = PH_START;
                            resume_next = 1'b1;
                            state_next  = CS_EMPTY;
                        end
                        else if (stat.is_slash)
                        begin
                            phase_next = PH_SLASH;
                            state_next = CS_WAIT;
                        end
                        else
                        begin
                            cmd.clear  = 1'b1;
                            state_next = CS_WAIT;
                            if (stat.is_quote)
                                phase_next = PH_STRING;
                            else
                            begin
                                cmd.append = 1'b1;
                                phase_next = eol_mode_reg ? PH_EOL : PH_WORD;
                            end
                        end
                    end
                    PH_SLASH:
                    begin
                        if (!stat.eot && (stat.is_slash || stat.is_star))
                        begin
                            saw_nl_next = 1'b0;
                            phase_next  = stat.is_slash ? PH_LINE : PH_BLOCK;
                            state_next  = CS_WAIT;
                        end
                        else
                        begin
                            // lone slash starts a token, byte is seen again
                            cmd.clear     = 1'b1;
                            cmd.append    = 1'b1;
                            cmd.app_slash = 1'b1;
                            phase_next    = eol_mode_reg ? PH_EOL : PH_WORD;
                        end
                    end
                    PH_LINE:
                    begin
                        if (stat.eot || stat.is_nl)
                        begin
                            saw_nl_next = 1'b0;
                            phase_next  = PH_SKIP;
                        end
                        else
                            state_next = CS_WAIT;
                    end
                    PH_BLOCK:
                    begin
                        if (stat.eot)
                            phase_next = PH_SKIP;
                        else
                        begin
                            if (stat.is_star)
                                phase_next = PH_BLOCK_STAR;
                            state_next = CS_WAIT;
                        end
                    end
                    PH_BLOCK_STAR:
                    begin
                        if (stat.eot)
                            phase_next = PH_SKIP;
                        else
                        begin
                            if (stat.is_slash)
                            begin
                                saw_nl_next = 1'b0;
                                phase_next  = PH_SKIP;
                            end
                            else if (!stat.is_star)
                                phase_next = PH_BLOCK;
                            state_next = CS_WAIT;
                        end
                    end
                    PH_STRING:
                    begin
                        if (stat.eot || stat.is_quote)
                        begin
                            cmd.finish  = 1'b1;
                            saw_nl_next = 1'b0;
                            phase_next  = PH_START;
                            resume_next = stat.eot;
                            state_next  = stat.raw_ok ? CS_RD : CS_EMPTY;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            state_next = CS_WAIT;
                        end
                    end
                    PH_EOL:
                    begin
                        if (stat.eot || stat.is_nl || stat.is_cr)
                        begin
                            cmd.finish  = 1'b1;
                            cmd.trim    = 1'b1;
                            saw_nl_next = 1'b0;
                            phase_next  = PH_START;
                            resume_next = 1'b1;
                            state_next  = stat.trim_ok ? CS_RD : CS_EMPTY;
                        end
                        else if (stat.is_slash)
                        begin
                            phase_next = PH_EOL_SLASH;
                            state_next = CS_WAIT;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            state_next = CS_WAIT;
                        end
                    end
                    PH_EOL_SLASH:
                    begin
                        if (!stat.eot && (stat.is_slash || stat.is_star))
                        begin
                            // comment start ends the token; held slash opens next scan
                            cmd.finish    = 1'b1;
                            cmd.trim      = 1'b1;
                            allow_next    = stat.allow;
                            eol_mode_next = stat.eol;
                            saw_nl_next   = 1'b0;
                            phase_next    = PH_SLASH;
                            resume_next   = 1'b1;
                            state_next    = stat.trim_ok ? CS_RD : CS_EMPTY;
                        end
                        else
                        begin
                            cmd.append    = 1'b1;
                            cmd.app_slash = 1'b1;
                            phase_next    = PH_EOL;
                        end
                    end
                    PH_WORD:
                    begin
                        if (stat.eot || stat.is_ws)
                        begin
                            cmd.finish  = 1'b1;
                            saw_nl_next = 1'b0;
                            phase_next  = PH_START;
                            resume_next = 1'b1;
                            state_next  = stat.raw_ok ? CS_RD : CS_EMPTY;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            state_next = CS_WAIT;
                        end
                    end
                    default:
                        phase_next = PH_START;
                endcase
            end
            CS_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.load_empty = 1'b1;
                    state_next     = resume_reg ? CS_EVAL : CS_WAIT;
                end
            end
            CS_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.load_mark = 1'b1;
                    state_next    = CS_DONE;
                end
            end
            CS_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = CS_WR;
            end
            CS_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_tok = 1'b1;
                    if (stat.rep_last)
                        state_next = resume_reg ? CS_EVAL : CS_WAIT;
                    else
                        state_next = CS_RD;
                end
            end
            CS_DONE:
                s_tready = 1'b1;   // text finished: transfers are taken and dropped
            default:
                state_next = CS_WAIT;
        endcase
    end

endmodule

// File: hw/rtl/stt_dpath.sv
// Scanner datapath: input latch, token store, length tracking, output register.
module stt_dpath import stt_pkg::*; #(
    parameter int TOKEN_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  stt_cmd_t    cmd,
    output stt_stat_t   stat,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);

    localparam int LW = $clog2(TOKEN_DEPTH + 1);
    localparam int AW = $clog2(TOKEN_DEPTH);

    logic [7:0]    ch_reg;
    logic          eot_reg;
    logic          allow_in_reg;
    logic          eol_in_reg;

    logic [7:0]    mem [TOKEN_DEPTH];
    logic [7:0]    rdata_reg;

    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] keep_reg, keep_next;    // length up to last byte at or above space
    logic [LW-1:0] emit_len_reg;
    logic [AW-1:0] idx_reg;

    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;
    logic          out_empty_reg;
    logic          out_done_reg;

    logic [7:0]    app_byte;
    logic [LW-1:0] len_base;
    logic [LW-1:0] keep_base;
    logic          wr_en;

    assign app_byte  = cmd.app_slash ? CH_SLASH : ch_reg;
    assign len_base  = cmd.clear ? '0 : len_reg;
    assign keep_base = cmd.clear ? '0 : keep_reg;
    assign wr_en     = cmd.append && (len_base < LW'(TOKEN_DEPTH));

    always_comb
    begin
        len_next  = len_base;
        keep_next = keep_base;
        if (cmd.finish)
        begin
            len_next  = '0;
            keep_next = '0;
        end
        else if (wr_en)
        begin
            len_next = len_base + LW'(1);
            if (app_byte >= CH_SPACE)
                keep_next = len_base + LW'(1);
        end
    end

    // input transfer latch
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ch_reg       <= s_tdata[7:0];
            eot_reg      <= s_tlast;
            allow_in_reg <= s_tdata[8];
            eol_in_reg   <= s_tdata[9];
        end
    end

    // token store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[len_base[AW-1:0]] <= app_byte;
        if (cmd.rd)
            rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            keep_reg     <= '0;
            emit_len_reg <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            keep_reg <= keep_next;
            if (cmd.finish)
            begin
                emit_len_reg <= cmd.trim ? keep_reg : len_reg;
                idx_reg      <= '0;
            end
            else if (cmd.load_tok)
                idx_reg <= idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_tok || cmd.load_empty || cmd.load_mark)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_tok)
        begin
            out_char_reg  <= rdata_reg;
            out_last_reg  <= stat.rep_last;
            out_empty_reg <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else if (cmd.load_empty || cmd.load_mark)
        begin
            out_char_reg  <= 8'h00;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
            out_done_reg  <= cmd.load_mark;
        end
    end

    always_comb
    begin
        stat.eot      = eot_reg;
        stat.allow    = allow_in_reg;
        stat.eol      = eol_in_reg;
        stat.is_ws    = ch_reg <= CH_SPACE;
        stat.is_nl    = ch_reg == CH_LF;
        stat.is_cr    = ch_reg == CH_CR;
        stat.is_slash = ch_reg == CH_SLASH;
        stat.is_star  = ch_reg == CH_STAR;
        stat.is_quote = ch_reg == CH_QUOTE;
        stat.raw_ok   = (len_reg != '0) && (len_reg < LW'(TOKEN_DEPTH));
        stat.trim_ok  = (keep_reg != '0) && (keep_reg < LW'(TOKEN_DEPTH));
        stat.rep_last = (LW'(idx_reg) + LW'(1)) == emit_len_reg;
        stat.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_done_reg, out_empty_reg};

endmodule

// File: hw/rtl/script_token_scanner.sv
// Script token scanner: text bytes in, tokens out as byte runs.
//
// Input stream: one text byte per transfer. s_tdata[7:0] is the byte, s_tdata[8]
// allows line breaks and s_tdata[9] selects rest-of-line tokens (both sampled when
// a token scan begins); s_tlast marks the terminating NUL of the text.
// Output stream: one token byte per transfer on m_tdata, m_tlast on the last
// byte of a token, m_tuser[0] for an empty token, m_tuser[1] for the end marker.
// Each input byte is taken in a wait state and then evaluated; a phase change
// may evaluate the held byte again before the next byte is taken. A finished token
// is then replayed from the token store byte by byte (store read, then output
// register load) before new input is taken.
// Reset puts the scanner at the start of a fresh scan with an empty token.
// When the receiver stalls the output register holds and the controller waits;
// input is not taken until the last result of a token is in the output register.
// After the end marker every input transfer is taken and dropped until reset.
`include "script_token_scanner_assert.svh"
module script_token_scanner import stt_pkg::*; #(
    parameter int TOKEN_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] ch, [8] allow_line_breaks, [9] read_to_eol
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tok_char
    output logic        m_tlast,   // tok_last
    output logic [1:0]  m_tuser    // [0] tok_empty, [1] text_done
);

    stt_cmd_t  cmd;
    stt_stat_t stat;

    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stt_dpath #(
        .TOKEN_DEPTH (TOKEN_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `STT_ASSERT_IMPL(a_marker_form, m_tvalid && m_tuser[1], m_tlast && m_tuser[0])
    `STT_ASSERT_IMPL(a_empty_zero, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 8'h00))
    `STT_ASSERT_NEXT(a_silent_after_end, m_tvalid && m_tready && m_tuser[1], !m_tvalid)

endmodule
